// File: sv/csfw_pkg.sv
// csfw_pkg: shared types and codes for the counting semaphore with fifo waiters
// used by csfw_wq and counting_semaphore_fifo_waiters_unit
// no dependencies
package csfw_pkg;

  // operation codes carried by in_mode
  typedef enum logic [2:0] {
    MODE_WAIT   = 3'd0,
    MODE_POST   = 3'd1,
    MODE_CANCEL = 3'd2,
    MODE_DELETE = 3'd3,
    MODE_CREATE = 3'd4
  } mode_t;

  // result codes carried by out_status
  typedef enum logic [3:0] {
    STS_ACQUIRED    = 4'd0,
    STS_QUEUED      = 4'd1,
    STS_WOULD_BLOCK = 4'd2,
    STS_GRANTED     = 4'd3,
    STS_INCREMENTED = 4'd4,
    STS_OVERFLOW    = 4'd5,
    STS_WOKEN_ERR   = 4'd6,
    STS_DELETED     = 4'd7,
    STS_CANCELLED   = 4'd8,
    STS_NOT_FOUND   = 4'd9,
    STS_INVALID     = 4'd10,
    STS_FULL        = 4'd11,
    STS_CREATED     = 4'd12
  } status_t;

  // configuration register indexes
  localparam logic CFG_MAX_COUNT     = 1'b0;
  localparam logic CFG_INITIAL_COUNT = 1'b1;

  // waiter queue commands, one per cycle
  typedef enum logic [2:0] {
    WQ_NOP   = 3'd0,
    WQ_PUSH  = 3'd1,  // write data at the tail, grow by one
    WQ_READ  = 3'd2,  // read entry at a logical index, data next cycle
    WQ_POP   = 3'd3,  // drop the head entry
    WQ_WRITE = 3'd4,  // overwrite entry at a logical index
    WQ_DROP  = 3'd5,  // drop the tail entry
    WQ_CLEAR = 3'd6   // empty the queue
  } wq_op_t;

  // sequencer states
  typedef enum logic [3:0] {
    SQ_IDLE,
    SQ_EXEC,
    SQ_POST_RD,
    SQ_CAN_RD,
    SQ_CAN_CMP,
    SQ_SH_RD,
    SQ_SH_WR,
    SQ_DEL_CHK,
    SQ_DEL_EMIT
  } seq_state_t;

endpackage

// File: sv/counting_semaphore_fifo_waiters_unit.sv
// counting_semaphore_fifo_waiters_unit: counting semaphore with a fifo of waiting tasks
// depends on csfw_pkg and csfw_wq
//
// channel  direction  handshake           payload
// in       input      in_valid/in_stall   in_mode[2:0] in_task_id[7:0] in_no_wait
// out      output     out_valid/out_stall out_status[3:0] out_task_id_out[7:0]
//                                         out_count_out[15:0] out_last
// cfg      input      cfg_we (no wait)    cfg_index cfg_wdata[15:0]
//
// steps: create, wait, invalid and post without waiters pass accept and execute;
// post that grants a waiter adds one queue read; cancel visits each queued entry:
// each entry is either scanned (read, compare) or shifted down (read, write), as
// the single queue memory port pair allows; delete reads and reports each waiter
// in turn, then reports the delete; a new transaction
// is taken only once the last result is loaded
// reset is synchronous, active low: semaphore not live, count 0, queue empty
// out_stall holds the result register and the sequencer waits on it
module counting_semaphore_fifo_waiters_unit import csfw_pkg::*; #(
  parameter int unsigned MAX_WAITERS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_mode,
  input  logic [7:0]  in_task_id,
  input  logic        in_no_wait,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_status,
  output logic [7:0]  out_task_id_out,
  output logic [15:0] out_count_out,
  output logic        out_last,
  // configuration port
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata
);

  localparam int unsigned CW = $clog2(MAX_WAITERS + 1);

  // configuration registers
  logic [15:0] max_count_r;
  logic [15:0] initial_count_r;

  // semaphore state
  seq_state_t  state_r, state_nxt;
  logic [15:0] sem_count_r, sem_count_nxt;
  logic [15:0] held_max_r, held_max_nxt;
  logic        live_r, live_nxt;
  logic [CW-1:0] idx_r, idx_nxt;

  // latched transaction
  logic [2:0]  mode_r;
  logic [7:0]  tid_r;
  logic        nowait_r;

  // result register
  logic        out_valid_r;
  logic [3:0]  out_status_r;
  logic [7:0]  out_tid_r;
  logic [15:0] out_count_r;
  logic        out_last_r;

  // result to load this cycle
  logic        emit;
  status_t     em_status;
  logic [7:0]  em_tid;
  logic [15:0] em_count;
  logic        em_last;

  // queue command
  wq_op_t        wq_op;
  logic [CW-1:0] wq_idx;
  logic [7:0]    wq_wdata;
  logic [CW-1:0] wq_occ;
  logic [7:0]    wq_rd_data;

  logic        in_accept;
  logic        can_emit;
  logic        create_bad;

  assign in_stall  = (state_r != SQ_IDLE);
  assign in_accept = in_valid && !in_stall;
  // result register is free or drains this cycle
  assign can_emit  = !out_valid_r || !out_stall;
  assign create_bad = live_r || (max_count_r == '0) || (initial_count_r > max_count_r);

  csfw_wq #(
    .MAX_WAITERS(MAX_WAITERS)
  ) u_wq (
    .clk     (clk),
    .rst_n   (rst_n),
    .op      (wq_op),
    .idx     (wq_idx),
    .wdata   (wq_wdata),
    .occ     (wq_occ),
    .rd_data (wq_rd_data)
  );

  // push stores the caller, shift rewrites the entry just read
  assign wq_wdata = (wq_op == WQ_PUSH) ? tid_r : wq_rd_data;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_count_r     <= 16'd1;
      initial_count_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAX_COUNT:     max_count_r     <= cfg_wdata;
        CFG_INITIAL_COUNT: initial_count_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // latch the accepted transaction
  always_ff @(posedge clk) begin
    if (in_accept) begin
      mode_r   <= in_mode;
      tid_r    <= in_task_id;
      nowait_r <= in_no_wait;
    end
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    sem_count_nxt = sem_count_r;
    held_max_nxt  = held_max_r;
    live_nxt      = live_r;
    idx_nxt       = idx_r;
    wq_op         = WQ_NOP;
    wq_idx        = idx_r;
    emit          = 1'b0;
    em_status     = STS_INVALID;
    em_tid        = '0;
    em_count      = sem_count_r;
    em_last       = 1'b1;

    case (state_r)
      SQ_IDLE: begin
        if (in_accept) begin
          state_nxt = SQ_EXEC;
        end
      end

      SQ_EXEC: begin
        if (mode_r == MODE_CREATE) begin
          if (can_emit) begin
            emit      = 1'b1;
            state_nxt = SQ_IDLE;
            if (!create_bad) begin
              em_status     = STS_CREATED;
              em_count      = initial_count_r;
              sem_count_nxt = initial_count_r;
              held_max_nxt  = max_count_r;
              live_nxt      = 1'b1;
              wq_op         = WQ_CLEAR;
            end
          end
        end else if (!live_r || mode_r > MODE_CREATE) begin
          // unknown codes and anything on a dead semaphore
          if (can_emit) begin
            emit      = 1'b1;
            state_nxt = SQ_IDLE;
          end
        end else begin
          case (mode_r)
            MODE_WAIT: begin
              if (can_emit) begin
                emit      = 1'b1;
                em_tid    = tid_r;
                state_nxt = SQ_IDLE;
                if (sem_count_r != '0) begin
                  em_status     = STS_ACQUIRED;
                  sem_count_nxt = sem_count_r - 16'd1;
                  em_count      = sem_count_nxt;
                end else if (nowait_r) begin
                  em_status = STS_WOULD_BLOCK;
                end else if (wq_occ == CW'(MAX_WAITERS)) begin
                  em_status = STS_FULL;
                end else begin
                  em_status = STS_QUEUED;
                  wq_op     = WQ_PUSH;
                end
              end
            end
            MODE_POST: begin
              if (wq_occ != '0) begin
                // fetch the oldest waiter
                wq_op     = WQ_READ;
                wq_idx    = '0;
                state_nxt = SQ_POST_RD;
              end else if (can_emit) begin
                emit      = 1'b1;
                state_nxt = SQ_IDLE;
                if (sem_count_r < held_max_r) begin
                  em_status     = STS_INCREMENTED;
                  sem_count_nxt = sem_count_r + 16'd1;
                  em_count      = sem_count_nxt;
                end else begin
                  em_status = STS_OVERFLOW;
                end
              end
            end
            MODE_CANCEL: begin
              idx_nxt   = '0;
              state_nxt = SQ_CAN_RD;
            end
            default: begin
              // delete
              state_nxt = SQ_DEL_CHK;
            end
          endcase
        end
      end

      SQ_POST_RD: begin
        if (can_emit) begin
          emit      = 1'b1;
          em_status = STS_GRANTED;
          em_tid    = wq_rd_data;
          wq_op     = WQ_POP;
          state_nxt = SQ_IDLE;
        end
      end

      // cancel scan: read one entry, compare it next cycle
      SQ_CAN_RD: begin
        if (idx_r == wq_occ) begin
          if (can_emit) begin
            emit      = 1'b1;
            em_status = STS_NOT_FOUND;
            em_tid    = tid_r;
            state_nxt = SQ_IDLE;
          end
        end else begin
          wq_op     = WQ_READ;
          state_nxt = SQ_CAN_CMP;
        end
      end

      SQ_CAN_CMP: begin
        idx_nxt = idx_r + CW'(1);
        if (wq_rd_data == tid_r) begin
          state_nxt = SQ_SH_RD;
        end else begin
          state_nxt = SQ_CAN_RD;
        end
      end

      // close the gap: move each later entry down by one, then drop the tail
      SQ_SH_RD: begin
        if (idx_r == wq_occ) begin
          if (can_emit) begin
            emit      = 1'b1;
            em_status = STS_CANCELLED;
            em_tid    = tid_r;
            wq_op     = WQ_DROP;
            state_nxt = SQ_IDLE;
          end
        end else begin
          wq_op     = WQ_READ;
          state_nxt = SQ_SH_WR;
        end
      end

      SQ_SH_WR: begin
        wq_op     = WQ_WRITE;
        wq_idx    = idx_r - CW'(1);
        idx_nxt   = idx_r + CW'(1);
        state_nxt = SQ_SH_RD;
      end

      // delete: wake waiters oldest first, then report
      SQ_DEL_CHK: begin
        if (wq_occ != '0) begin
          wq_op     = WQ_READ;
          wq_idx    = '0;
          state_nxt = SQ_DEL_EMIT;
        end else if (can_emit) begin
          emit          = 1'b1;
          em_status     = STS_DELETED;
          em_count      = '0;
          sem_count_nxt = '0;
          live_nxt      = 1'b0;
          wq_op         = WQ_CLEAR;
          state_nxt     = SQ_IDLE;
        end
      end

      SQ_DEL_EMIT: begin
        if (can_emit) begin
          emit      = 1'b1;
          em_status = STS_WOKEN_ERR;
          em_tid    = wq_rd_data;
          em_last   = 1'b0;
          wq_op     = WQ_POP;
          state_nxt = SQ_DEL_CHK;
        end
      end

      default: state_nxt = SQ_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= SQ_IDLE;
      sem_count_r <= '0;
      held_max_r  <= '0;
      live_r      <= 1'b0;
      idx_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      sem_count_r <= sem_count_nxt;
      held_max_r  <= held_max_nxt;
      live_r      <= live_nxt;
      idx_r       <= idx_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_status_r <= em_status;
      out_tid_r    <= em_tid;
      out_count_r  <= em_count;
      out_last_r   <= em_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_task_id_out = out_tid_r;
  assign out_count_out   = out_count_r;
  assign out_last        = out_last_r;

  // checks
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    wq_occ <= CW'(MAX_WAITERS))
    else $error("waiter occupancy above depth");

  a_dead_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !live_r |-> wq_occ == '0)
    else $error("waiters present on a semaphore that is not live");

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> state_r == SQ_EXEC)
    else $error("accepted transaction not executed");

  a_delete_clean: assert property (@(posedge clk) disable iff (!rst_n)
    emit && em_status == STS_DELETED |=> !live_r && sem_count_r == '0)
    else $error("delete left the semaphore live");

endmodule

// File: sv/csfw_wq.sv
// csfw_wq: circular waiter queue, one memory port pair and a shared index adder
// depends on csfw_pkg (wq_op_t)
module csfw_wq import csfw_pkg::*; #(
  parameter int unsigned MAX_WAITERS = 16,
  localparam int unsigned AW = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1,
  localparam int unsigned CW = $clog2(MAX_WAITERS + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  wq_op_t        op,
  input  logic [CW-1:0] idx,
  input  logic [7:0]    wdata,
  output logic [CW-1:0] occ,
  output logic [7:0]    rd_data
);

  localparam int unsigned SW = AW + 1;

  logic [7:0]    mem [MAX_WAITERS];
  logic [AW-1:0] head_r, head_nxt;
  logic [CW-1:0] occ_r, occ_nxt;
  logic [7:0]    rd_data_r;
  logic [CW-1:0] sel_idx;
  logic [SW-1:0] sum;
  logic [SW-1:0] wrapped;
  logic [AW-1:0] phys;

  // logical to physical: head plus index, folded once past the depth
  always_comb begin
    sel_idx = (op == WQ_PUSH) ? occ_r : idx;
    sum     = {1'b0, head_r} + SW'(sel_idx);
    wrapped = (sum >= SW'(MAX_WAITERS)) ? sum - SW'(MAX_WAITERS) : sum;
    phys    = wrapped[AW-1:0];
  end

  always_comb begin
    head_nxt = head_r;
    occ_nxt  = occ_r;
    case (op)
      WQ_PUSH: occ_nxt = occ_r + CW'(1);
      WQ_POP: begin
        occ_nxt  = occ_r - CW'(1);
        head_nxt = (head_r == AW'(MAX_WAITERS - 1)) ? '0 : head_r + AW'(1);
      end
      WQ_DROP: occ_nxt = occ_r - CW'(1);
      WQ_CLEAR: begin
        occ_nxt  = '0;
        head_nxt = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      occ_r  <= '0;
    end else begin
      head_r <= head_nxt;
      occ_r  <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (op == WQ_PUSH || op == WQ_WRITE) begin
      mem[phys] <= wdata;
    end
    if (op == WQ_READ) begin
      rd_data_r <= mem[phys];
    end
  end

  assign occ     = occ_r;
  assign rd_data = rd_data_r;

endmodule

// File: dv/counting_semaphore_fifo_waiters_unit_tb.sv
// testbench for counting_semaphore_fifo_waiters_unit: directed and random semaphore calls,
// each result checked in order against a built-in predictor of the semaphore
// depends on csfw_pkg and the rtl of counting_semaphore_fifo_waiters_unit
`timescale 1ns / 100ps

import csfw_pkg::*;

// one expected result transaction
typedef struct {
  status_t     status;
  logic [7:0]  task_id;
  logic [15:0] count;
  logic        last;
} sem_result_t;

class sem_scoreboard;
  int          depth;
  // configuration registers as the block holds them
  logic [15:0] max_reg;
  logic [15:0] init_reg;
  // semaphore state
  logic [15:0] count;
  logic [15:0] held_max;
  bit          live;
  logic [7:0]  waiters[$];
  sem_result_t results_due[$];
  int          errors;

  function new(int waiter_depth);
    depth    = waiter_depth;
    max_reg  = 16'd1;
    init_reg = 16'd0;
    count    = 16'd0;
    held_max = 16'd0;
    live     = 1'b0;
    errors   = 0;
  endfunction

  function void load_reg(logic idx, logic [15:0] val);
    if (idx == CFG_MAX_COUNT) max_reg = val;
    else init_reg = val;
  endfunction

  function void due(status_t st, logic [7:0] tid, logic fin);
    sem_result_t r;
    r.status  = st;
    r.task_id = tid;
    r.count   = count;
    r.last    = fin;
    results_due.push_back(r);
  endfunction

  // apply one accepted call and queue the results it causes
  function void apply_call(logic [2:0] mode, logic [7:0] tid, logic nw);
    int i;
    bit found;
    found = 1'b0;
    if (mode == MODE_CREATE) begin
      if (live || max_reg == 16'd0 || init_reg > max_reg) begin
        due(STS_INVALID, 8'd0, 1'b1);
      end else begin
        count    = init_reg;
        held_max = max_reg;
        waiters.delete();
        live     = 1'b1;
        due(STS_CREATED, 8'd0, 1'b1);
      end
    end else if (mode > MODE_CREATE || !live) begin
      due(STS_INVALID, 8'd0, 1'b1);
    end else begin
      case (mode)
        MODE_WAIT: begin
          if (count != 16'd0) begin
            count = count - 16'd1;
            due(STS_ACQUIRED, tid, 1'b1);
          end else if (nw) begin
            due(STS_WOULD_BLOCK, tid, 1'b1);
          end else if (waiters.size() >= depth) begin
            due(STS_FULL, tid, 1'b1);
          end else begin
            waiters.push_back(tid);
            due(STS_QUEUED, tid, 1'b1);
          end
        end
        MODE_POST: begin
          if (waiters.size() != 0) begin
            due(STS_GRANTED, waiters.pop_front(), 1'b1);
          end else if (count < held_max) begin
            count = count + 16'd1;
            due(STS_INCREMENTED, 8'd0, 1'b1);
          end else begin
            due(STS_OVERFLOW, 8'd0, 1'b1);
          end
        end
        MODE_CANCEL: begin
          // oldest matching entry only
          for (i = 0; i < waiters.size(); i++) begin
            if (!found && waiters[i] == tid) begin
              waiters.delete(i);
              found = 1'b1;
            end
          end
          due(found ? STS_CANCELLED : STS_NOT_FOUND, tid, 1'b1);
        end
        default: begin
          // delete: wake every waiter with an error, oldest first
          while (waiters.size() != 0) due(STS_WOKEN_ERR, waiters.pop_front(), 1'b0);
          count = 16'd0;
          live  = 1'b0;
          due(STS_DELETED, 8'd0, 1'b1);
        end
      endcase
    end
  endfunction

  function void check_result(logic [3:0] st, logic [7:0] tid, logic [15:0] cnt, logic fin);
    sem_result_t r;
    if (results_due.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("unexpected result: st %0d task %0d count %0d last %0d", st, tid, cnt, fin);
      return;
    end
    r = results_due.pop_front();
    if (st !== r.status || tid !== r.task_id || cnt !== r.count || fin !== r.last) begin
      errors++;
      if (errors <= 10)
        $display("mismatch: expected st %0d task %0d count %0d last %0d, got %0d %0d %0d %0d",
                 r.status, r.task_id, r.count, r.last, st, tid, cnt, fin);
    end
  endfunction
endclass

module counting_semaphore_fifo_waiters_unit_tb;

  localparam int WAITER_DEPTH  = 16;
  localparam int HOLD_CYCLES   = 80;   // long receiver hold-off, fills the block
  localparam int SETTLE_CYCLES = 12;   // idle margin after the last result
  localparam int PHASE_ITEMS   = 75;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_mode = MODE_WAIT;
  logic [7:0]  in_task_id = 8'd0;
  logic        in_no_wait = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [3:0]  out_status;
  logic [7:0]  out_task_id_out;
  logic [15:0] out_count_out;
  logic        out_last;
  logic        cfg_we = 1'b0;
  logic        cfg_index = CFG_MAX_COUNT;
  logic [15:0] cfg_wdata = 16'd0;

  // quiet: no idling on either side; hold_req: ask the receiver for a long hold-off
  // hold_done: the receiver has served that request
  logic        quiet = 1'b0;
  logic        hold_req = 1'b0;
  logic        hold_done = 1'b0;
  int          hold_left = 0;

  sem_scoreboard sb = new(WAITER_DEPTH);

  counting_semaphore_fifo_waiters_unit #(.MAX_WAITERS(WAITER_DEPTH)) uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_mode        (in_mode),
    .in_task_id     (in_task_id),
    .in_no_wait     (in_no_wait),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_task_id_out(out_task_id_out),
    .out_count_out  (out_count_out),
    .out_last       (out_last),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // receiver: random stalls, a counted hold-off on request, none while quiet
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (quiet) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < 24);
    end
  end

  // every accepted result transaction is checked against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_status, out_task_id_out, out_count_out, out_last);
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #(20 * 1000000);
    $display("status: fail");
    $finish;
  end

  // task ids: half from a small pool so duplicates and cancels hit
  function automatic logic [7:0] pick_tid();
    if ($urandom_range(0, 1)) return 8'($urandom_range(0, 7));
    return 8'($urandom_range(0, 255));
  endfunction

  // offer one call transaction, maybe after a random gap, and wait until taken
  task automatic send_op(logic [2:0] mode, logic [7:0] tid, logic nw);
    int gap;
    if (!quiet && $urandom_range(0, 99) < 24) begin
      gap = $urandom_range(1, 4);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_mode    <= mode;
    in_task_id <= tid;
    in_no_wait <= nw;
    do @(posedge clk); while (in_stall);
    sb.apply_call(mode, tid, nw);
  endtask

  // stop offering and wait until every expected result is in
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // register write, only ever issued while the block is idle
  task automatic write_reg(logic idx, logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.load_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic set_counts(logic [15:0] max_val, logic [15:0] init_val);
    drain();
    write_reg(CFG_MAX_COUNT, max_val);
    write_reg(CFG_INITIAL_COUNT, init_val);
  endtask

  // mostly legal call sequences on a live semaphore, some noise
  task automatic random_phase(int n_items, bit with_hold);
    int          sent;
    int          pick;
    int          k;
    bit          held;
    logic [2:0]  mode;
    logic [7:0]  tid;
    logic        nw;
    held = 1'b0;
    // start from a fresh semaphore under the new counts
    send_op(MODE_DELETE, pick_tid(), 1'($urandom_range(0, 1)));
    send_op(MODE_CREATE, pick_tid(), 1'($urandom_range(0, 1)));
    sent = 2;
    while (sent < n_items) begin
      if (with_hold && !held && sent >= 20) begin
        // receiver goes quiet for a long stretch while calls keep coming
        hold_req <= 1'b1;
        held = 1'b1;
      end
      pick = $urandom_range(0, 99);
      tid  = pick_tid();
      nw   = 1'($urandom_range(0, 1));
      if (sb.live && pick < 4) begin
        // burst of blocking waits, runs the queue to full
        for (k = 0; k < 18; k++) send_op(MODE_WAIT, pick_tid(), 1'b0);
        sent += 18;
      end else begin
        if (!sb.live) begin
          mode = (pick < 85) ? 3'(MODE_CREATE) : 3'($urandom_range(0, 7));
        end else if (pick < 45) begin
          mode = MODE_WAIT;
          nw   = ($urandom_range(0, 99) < 20);
        end else if (pick < 70) begin
          mode = MODE_POST;
        end else if (pick < 85) begin
          mode = MODE_CANCEL;
          if (sb.waiters.size() != 0 && $urandom_range(0, 99) < 70)
            tid = sb.waiters[$urandom_range(0, sb.waiters.size() - 1)];
        end else if (pick < 91) begin
          mode = MODE_DELETE;
        end else if (pick < 95) begin
          mode = MODE_CREATE;
        end else begin
          mode = 3'($urandom_range(5, 7));
        end
        send_op(mode, tid, nw);
        sent++;
      end
    end
  endtask

  initial begin
    logic [15:0] max_val;
    // synchronous reset at the start
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, reset counts (binary semaphore, empty)
    // calls on a semaphore that is not live, and unknown modes
    send_op(MODE_WAIT,   8'h00, 1'b0);
    send_op(MODE_POST,   8'hFF, 1'b1);
    send_op(MODE_CANCEL, 8'h01, 1'b0);
    send_op(MODE_DELETE, 8'h02, 1'b1);
    send_op(3'd5, 8'hFF, 1'b1);
    send_op(3'd6, 8'h80, 1'b0);
    send_op(3'd7, 8'h7F, 1'b1);
    send_op(MODE_CREATE, 8'h00, 1'b0);
    // create while live
    send_op(MODE_CREATE, 8'h00, 1'b0);
    send_op(MODE_WAIT,   8'hA5, 1'b1);
    send_op(MODE_WAIT,   8'hFF, 1'b0);
    send_op(MODE_WAIT,   8'h00, 1'b0);
    // same task queued twice, cancel takes the oldest
    send_op(MODE_WAIT,   8'hFF, 1'b0);
    send_op(MODE_CANCEL, 8'hFF, 1'b0);
    send_op(MODE_CANCEL, 8'h5A, 1'b1);
    send_op(MODE_POST,   8'h00, 1'b0);
    send_op(MODE_POST,   8'h00, 1'b0);
    send_op(MODE_POST,   8'h00, 1'b0);
    // post at the maximum
    send_op(MODE_POST,   8'h00, 1'b0);
    send_op(MODE_WAIT,   8'h11, 1'b0);
    send_op(MODE_WAIT,   8'h22, 1'b0);
    send_op(MODE_DELETE, 8'h00, 1'b0);

    // zero maximum and initial above maximum both refuse create
    set_counts(16'd0, 16'd0);
    send_op(MODE_CREATE, 8'h00, 1'b0);
    set_counts(16'd5, 16'd6);
    send_op(MODE_CREATE, 8'h00, 1'b0);
    // widest counts
    set_counts(16'hFFFF, 16'hFFFF);
    send_op(MODE_CREATE, 8'h00, 1'b0);
    send_op(MODE_POST,   8'h00, 1'b0);
    send_op(MODE_WAIT,   8'h33, 1'b1);
    send_op(MODE_DELETE, 8'h00, 1'b0);

    // random phases across several count settings
    set_counts(16'd3, 16'd0);
    quiet <= 1'b1;
    random_phase(PHASE_ITEMS, 1'b0);
    set_counts(16'hFFFF, 16'd0);
    quiet <= 1'b0;
    random_phase(PHASE_ITEMS, 1'b1);
    set_counts(16'd1, 16'd1);
    random_phase(PHASE_ITEMS, 1'b0);
    max_val = 16'($urandom_range(1, 8));
    set_counts(max_val, 16'($urandom_range(0, max_val)));
    random_phase(PHASE_ITEMS, 1'b0);
    set_counts(16'hFFFF, 16'hFFFF);
    random_phase(PHASE_ITEMS, 1'b0);
    max_val = 16'($urandom_range(1, 65535));
    set_counts(max_val, 16'($urandom_range(0, max_val)));
    random_phase(PHASE_ITEMS, 1'b0);

    drain();
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
